@@ rtl/deq_pkg.sv @@
package deq_pkg;

    // Field widths of the item and result channels.
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int OCC_W    = 7;

    // Default number of store entries.
    localparam int DEF_CAPACITY = 64;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // One result item as it moves from the sequencer to the output register.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         position;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } t_result;

    function automatic t_result mk_result(
        input logic [DATA_W-1:0]   value,
        input logic [STATUS_W-1:0] status,
        input logic [POS_W-1:0]    position,
        input logic [OCC_W-1:0]    occupancy,
        input logic                last
    );
        t_result r;
        r.value     = value;
        r.status    = status;
        r.position  = position;
        r.occupancy = occupancy;
        r.last      = last;
        return r;
    endfunction

endpackage

@@ rtl/double_ended_queue_unit.sv @@
// Bounded double-ended queue of signed 32-bit values in a circular store of
// CAPACITY entries (2 to 64). Each accepted item is one operation: push front,
// push back, pop front, pop back, search, forward dump or backward dump. Every
// operation yields one result with o_last set, except a dump of a non-empty
// queue, which yields one result per element in order with o_last on the
// final one. The block works on one item at a time and all elements share a
// single store with one read and one write port, so a search reads the
// elements one at a time from the front until a match or the back element,
// and a dump reads one element for each result it yields.
// The result register lets
// the next item be taken while the last result still waits for o_valid to be
// taken. Store contents are undefined after reset and need no clearing pass;
// only occupied entries are ever read.
module double_ended_queue_unit #(
    parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Item channel.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [deq_pkg::OP_W-1:0]          i_op,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    // Result channel.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [deq_pkg::DATA_W-1:0] o_result_value,
    output logic [deq_pkg::STATUS_W-1:0]      o_status,
    output logic [deq_pkg::POS_W-1:0]         o_position,
    output logic [deq_pkg::OCC_W-1:0]         o_occupancy_out,
    output logic                              o_last
);
    import deq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic              w_can_load;
    logic              w_load;
    t_result           w_res;
    logic              r_out_valid;
    t_result           r_out;

    deq_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_can_load (w_can_load),
        .o_load     (w_load),
        .o_res      (w_res),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    deq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Output register: loads when empty or when its result is being transferred.
    assign w_can_load = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_value  = r_out.value;
    assign o_status        = r_out.status;
    assign o_position      = r_out.position;
    assign o_occupancy_out = r_out.occupancy;
    assign o_last          = r_out.last;

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_out_valid || i_ready))
        else $error("result register overwritten while waiting");

    // Occupancy never exceeds the capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy_out <= OCC_W'(CAPACITY)))
        else $error("occupancy above capacity");

    // A dropped push is reported only when the queue is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_occupancy_out == OCC_W'(CAPACITY)))
        else $error("full status with free entries");

    // An empty report comes only from an empty queue.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_occupancy_out == '0))
        else $error("empty status with stored elements");

endmodule

@@ rtl/deq_store.sv @@
module deq_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [deq_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [deq_pkg::DATA_W-1:0] o_rdata
);
    import deq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deq_ctrl.sv @@
module deq_ctrl #(
    parameter int CAPACITY = deq_pkg::DEF_CAPACITY,
    parameter int AW       = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Item channel.
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [deq_pkg::OP_W-1:0]   i_op,
    input  logic [deq_pkg::DATA_W-1:0] i_value,
    // Result hand-off to the output register.
    input  logic                       i_can_load,
    output logic                       o_load,
    output deq_pkg::t_result           o_res,
    // Store ports.
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [deq_pkg::DATA_W-1:0] o_wdata,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    input  logic [deq_pkg::DATA_W-1:0] i_rdata
);
    import deq_pkg::*;

    localparam logic [AW:0]      CAP_X    = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0]    LAST_SLT = AW'(CAPACITY - 1);
    localparam logic [OCC_W-1:0] CAP_OCC  = OCC_W'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RESP = 5'b00010,
        S_POP  = 5'b00100,
        S_SCAN = 5'b01000,
        S_DUMP = 5'b10000
    } t_state;

    // Circular slot arithmetic; both operands are below the capacity.
    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
        return (a == LAST_SLT) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_SLT : a - AW'(1);
    endfunction

    t_state              r_state, n_state;
    logic [AW-1:0]       r_front, n_front;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [AW-1:0]       r_slot, n_slot;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_dir, n_dir;
    logic [DATA_W-1:0]   r_key, n_key;
    t_result             r_res, n_res;

    logic [OCC_W-1:0]    w_occ_m1;
    logic [AW-1:0]       w_back_slot;
    logic [AW-1:0]       w_push_slot;
    logic                w_full;
    logic                w_empty;
    logic                w_accept;
    logic                w_match;
    logic                w_at_end;
    logic                w_dump_last;

    // Slots of the back element and of the next free back entry.
    assign w_occ_m1    = r_occ - OCC_W'(1);
    assign w_back_slot = slot_add(r_front, w_occ_m1[AW-1:0]);
    assign w_push_slot = slot_add(r_front, r_occ[AW-1:0]);
    assign w_full      = (r_occ == CAP_OCC);
    assign w_empty     = (r_occ == '0);
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_match     = (i_rdata == r_key);
    assign w_at_end    = (r_pos == w_occ_m1[POS_W-1:0]);
    assign w_dump_last = r_dir ? (r_pos == '0) : w_at_end;

    // Sequencer: one store access per cycle, one item at a time.
    always_comb begin
        n_state = r_state;
        n_front = r_front;
        n_occ   = r_occ;
        n_slot  = r_slot;
        n_pos   = r_pos;
        n_dir   = r_dir;
        n_key   = r_key;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = w_push_slot;
        o_wdata = i_value;
        o_re    = 1'b0;
        o_raddr = r_slot;
        o_load  = 1'b0;
        o_res   = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key   = i_value;
                    n_state = S_RESP;
                    unique case (i_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_res = mk_result(i_value, ST_FULL, '0, r_occ, 1'b1);
                            end else if (i_op == OP_PUSH_FRONT) begin
                                o_we    = 1'b1;
                                o_waddr = slot_dec(r_front);
                                n_front = slot_dec(r_front);
                                n_occ   = r_occ + OCC_W'(1);
                                n_res   = mk_result(i_value, ST_OK, '0, n_occ, 1'b1);
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = w_push_slot;
                                n_occ   = r_occ + OCC_W'(1);
                                n_res   = mk_result(i_value, ST_OK, r_occ[POS_W-1:0],
                                                    n_occ, 1'b1);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (w_empty) begin
                                n_res = mk_result('0, ST_EMPTY, '0, r_occ, 1'b1);
                            end else begin
                                o_re    = 1'b1;
                                n_occ   = w_occ_m1;
                                n_state = S_POP;
                                if (i_op == OP_POP_FRONT) begin
                                    o_raddr = r_front;
                                    n_front = slot_inc(r_front);
                                    n_pos   = '0;
                                end else begin
                                    o_raddr = w_back_slot;
                                    n_pos   = w_occ_m1[POS_W-1:0];
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (w_empty) begin
                                n_res = mk_result('0, ST_NOT_FOUND, '0, r_occ, 1'b1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = r_front;
                                n_slot  = slot_inc(r_front);
                                n_pos   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_DUMP_FWD, OP_DUMP_BWD: begin
                            if (w_empty) begin
                                n_res = mk_result('0, ST_EMPTY, '0, r_occ, 1'b1);
                            end else begin
                                o_re    = 1'b1;
                                n_state = S_DUMP;
                                if (i_op == OP_DUMP_FWD) begin
                                    o_raddr = r_front;
                                    n_slot  = slot_inc(r_front);
                                    n_pos   = '0;
                                    n_dir   = 1'b0;
                                end else begin
                                    o_raddr = w_back_slot;
                                    n_slot  = slot_dec(w_back_slot);
                                    n_pos   = w_occ_m1[POS_W-1:0];
                                    n_dir   = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // Unused code: no change, one plain result.
                            n_res = mk_result('0, ST_OK, '0, r_occ, 1'b1);
                        end
                    endcase
                end
            end
            S_RESP: begin
                o_res = r_res;
                if (i_can_load) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                // Read data holds in the store until the result can move on.
                o_res = mk_result(i_rdata, ST_OK, r_pos, r_occ, 1'b1);
                if (i_can_load) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    o_res = mk_result(r_key, ST_OK, r_pos, r_occ, 1'b1);
                end else begin
                    o_res = mk_result('0, ST_NOT_FOUND, '0, r_occ, 1'b1);
                end
                if (w_match || w_at_end) begin
                    if (i_can_load) begin
                        o_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_slot;
                    n_slot  = slot_inc(r_slot);
                    n_pos   = r_pos + POS_W'(1);
                end
            end
            S_DUMP: begin
                o_res = mk_result(i_rdata, ST_OK, r_pos, r_occ, w_dump_last);
                if (i_can_load) begin
                    o_load = 1'b1;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_re    = 1'b1;
                        o_raddr = r_slot;
                        n_slot  = r_dir ? slot_dec(r_slot) : slot_inc(r_slot);
                        n_pos   = r_dir ? r_pos - POS_W'(1) : r_pos + POS_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_occ   <= n_occ;
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_pos  <= n_pos;
        r_dir  <= n_dir;
        r_key  <= n_key;
        r_res  <= n_res;
    end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int MAX_REPORTS = 10;

    // Op code 7 has no name in the package; the block treats it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Shadow copy of the queue contents plus the results it is expected to produce.
    class deque_shadow;
        logic signed [DATA_W-1:0] slots [CAP];
        int unsigned head;
        int unsigned count;
        t_result pending_results [$];
        int unsigned errors;

        function new();
            head   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function void add_result(logic signed [DATA_W-1:0] value,
                                 logic [STATUS_W-1:0] status,
                                 int unsigned pos, logic last);
            t_result r;
            r.value     = value;
            r.status    = status;
            r.position  = POS_W'(pos);
            r.occupancy = OCC_W'(count);
            r.last      = last;
            pending_results.push_back(r);
        endfunction

        // Apply one accepted operation to the shadow queue and queue its results.
        function void apply_operation(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
            int unsigned i;
            int unsigned pos;
            logic signed [DATA_W-1:0] v;
            bit found;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (count >= CAP) begin
                        add_result(value, ST_FULL, 0, 1'b1);
                    end else if (op == OP_PUSH_FRONT) begin
                        head = (head + CAP - 1) % CAP;
                        slots[head] = value;
                        count++;
                        add_result(value, ST_OK, 0, 1'b1);
                    end else begin
                        slots[(head + count) % CAP] = value;
                        count++;
                        add_result(value, ST_OK, count - 1, 1'b1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (count == 0) begin
                        add_result('0, ST_EMPTY, 0, 1'b1);
                    end else if (op == OP_POP_FRONT) begin
                        v = slots[head];
                        head = (head + 1) % CAP;
                        count--;
                        add_result(v, ST_OK, 0, 1'b1);
                    end else begin
                        v = slots[(head + count - 1) % CAP];
                        count--;
                        add_result(v, ST_OK, count, 1'b1);
                    end
                end
                OP_SEARCH: begin
                    // The first match from the front wins.
                    found = 1'b0;
                    for (i = 0; i < count && !found; i++) begin
                        if (slots[(head + i) % CAP] == value) begin
                            add_result(value, ST_OK, i, 1'b1);
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        add_result('0, ST_NOT_FOUND, 0, 1'b1);
                    end
                end
                OP_DUMP_FWD, OP_DUMP_BWD: begin
                    if (count == 0) begin
                        add_result('0, ST_EMPTY, 0, 1'b1);
                    end else begin
                        for (i = 0; i < count; i++) begin
                            pos = (op == OP_DUMP_FWD) ? i : count - 1 - i;
                            add_result(slots[(head + pos) % CAP], ST_OK, pos, i + 1 == count);
                        end
                    end
                end
                default: begin
                    add_result('0, ST_OK, 0, 1'b1);
                end
            endcase
        endfunction

        // Compare one result transfer with the oldest expected result.
        function void check_result(logic signed [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
                                   logic [POS_W-1:0] position, logic [OCC_W-1:0] occupancy,
                                   logic last);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("ERROR: result with none pending: value=%0d status=%0d pos=%0d occ=%0d last=%0b",
                             value, status, position, occupancy, last);
                end
                return;
            end
            want = pending_results.pop_front();
            if (want.value !== value || want.status !== status || want.position !== position ||
                want.occupancy !== occupancy || want.last !== last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("ERROR: expected value=%0d status=%0d pos=%0d occ=%0d last=%0b",
                             want.value, want.status, want.position, want.occupancy, want.last);
                    $display("       actual   value=%0d status=%0d pos=%0d occ=%0d last=%0b",
                             value, status, position, occupancy, last);
                end
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [OP_W-1:0]            i_op = OP_PUSH_FRONT;
    logic signed [DATA_W-1:0]   i_value = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [DATA_W-1:0]   o_result_value;
    logic [STATUS_W-1:0]        o_status;
    logic [POS_W-1:0]           o_position;
    logic [OCC_W-1:0]           o_occupancy_out;
    logic                       o_last;

    deque_shadow shadow;
    int unsigned cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    double_ended_queue_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_value  (o_result_value),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_occupancy_out (o_occupancy_out),
        .o_last          (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Every result transfer is checked as it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            shadow.check_result(o_result_value, o_status, o_position, o_occupancy_out, o_last);
        end
    end

    // Result side: random stalls, none while quiet, and one long hold on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    function automatic logic [OP_W-1:0] either(input logic [OP_W-1:0] a, input logic [OP_W-1:0] b);
        return $urandom_range(0, 1) ? a : b;
    endfunction

    // Values lean toward the extremes and a small pool so that searches hit duplicates.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom_range(0, 7);
            default: return $urandom();
        endcase
    endfunction

    // Search keys are taken from the current contents half of the time.
    function automatic logic signed [DATA_W-1:0] pick_key();
        if (shadow.count != 0 && $urandom_range(0, 1)) begin
            return shadow.slots[(shadow.head + $urandom_range(0, shadow.count - 1)) % CAP];
        end
        return pick_value();
    endfunction

    // Offer one item and hold it until the transfer completes.
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        @(negedge i_clk);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_value <= value;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        shadow.apply_operation(op, value);
    endtask

    // Stop offering items and wait for every outstanding result.
    task automatic await_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_mixed(input int n, input int push_pct, input int pop_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                send_item(either(OP_PUSH_FRONT, OP_PUSH_BACK), pick_value());
            end else if (r < push_pct + pop_pct) begin
                send_item(either(OP_POP_FRONT, OP_POP_BACK), pick_value());
            end else if (r < push_pct + pop_pct + 12) begin
                send_item(OP_SEARCH, pick_key());
            end else if (r < 97) begin
                send_item(either(OP_DUMP_FWD, OP_DUMP_BWD), pick_value());
            end else begin
                send_item(OP_UNUSED, pick_value());
            end
        end
    endtask

    initial begin : stimulus
        int r;
        shadow = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: pops, search, both dumps and the unused code.
        send_item(OP_POP_FRONT, 32'sd1);
        send_item(OP_POP_BACK, 32'sd2);
        send_item(OP_SEARCH, 32'sd5);
        send_item(OP_DUMP_FWD, '0);
        send_item(OP_DUMP_BWD, '0);
        send_item(OP_UNUSED, 32'sh80000000);
        // Extremes at both ends; the first push front wraps the head index.
        send_item(OP_PUSH_FRONT, 32'sh7FFFFFFF);
        send_item(OP_PUSH_BACK, 32'sh80000000);
        send_item(OP_PUSH_FRONT, '1);
        send_item(OP_PUSH_BACK, '0);
        send_item(OP_SEARCH, 32'sh80000000);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_PUSH_BACK, '1);
        send_item(OP_SEARCH, '1);
        send_item(OP_DUMP_FWD, '0);
        send_item(OP_DUMP_BWD, '1);
        send_item(OP_UNUSED, 32'sh7FFFFFFF);
        send_item(OP_POP_FRONT, '0);
        send_item(OP_POP_BACK, '0);
        send_item(OP_SEARCH, 32'sh7FFFFFFF);
        send_item(OP_DUMP_FWD, '0);
        await_results();

        // Mixed traffic, then a full pause.
        run_mixed(70, 45, 30);
        await_results();

        // Fill to capacity while the result side holds off, then push into a full queue.
        hold_req = 1'b1;
        while (shadow.count < CAP) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(OP_SEARCH, pick_key());
            end else begin
                send_item(either(OP_PUSH_FRONT, OP_PUSH_BACK), pick_value());
            end
        end
        repeat (4) send_item(either(OP_PUSH_FRONT, OP_PUSH_BACK), pick_value());
        send_item(OP_SEARCH, pick_key());
        send_item(OP_DUMP_FWD, '0);
        send_item(OP_DUMP_BWD, '0);

        // A stretch with no idling on either side.
        quiet = 1'b1;
        run_mixed(60, 40, 35);
        quiet = 1'b0;

        // Drain to empty, then hit the empty cases again.
        while (shadow.count > 0) begin
            r = $urandom_range(0, 19);
            if (r < 17) begin
                send_item(either(OP_POP_FRONT, OP_POP_BACK), pick_value());
            end else if (r < 19) begin
                send_item(OP_SEARCH, pick_key());
            end else begin
                send_item(either(OP_DUMP_FWD, OP_DUMP_BWD), pick_value());
            end
        end
        send_item(OP_POP_FRONT, pick_value());
        send_item(OP_POP_BACK, pick_value());
        send_item(OP_SEARCH, pick_value());
        send_item(OP_DUMP_BWD, pick_value());

        run_mixed(50, 35, 35);
        await_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
